FILE: hdl/mh64_pkg.sv
// shared types, constants and codes of the murmurhash64a engine
`timescale 1ns / 1ps
package mh64_pkg;

    localparam logic [63:0] MH_MULT = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MH_MULT_LO = MH_MULT[31:0];
    localparam logic [31:0] MH_MULT_HI = MH_MULT[63:32];
    localparam int MH_SHIFT = 47;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 64;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TAIL = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  kind;
        logic        first;
        logic        last;
        logic [63:0] seed;
        logic [31:0] key_length;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

endpackage

FILE: hdl/mh64_front.sv
// input side: accepts transfers, classifies word kind and masks tail bytes
`timescale 1ns / 1ps
module mh64_front (
    input  logic                            i_valid,
    input  logic [mh64_pkg::S_TDATA_W-1:0]  i_data,
    input  logic                            i_last,
    input  logic                            i_user,
    input  logic                            i_full,
    output logic                            o_ready,
    output logic                            o_push,
    output mh64_pkg::t_item                 o_item
);
    import mh64_pkg::*;

    logic [3:0]  nbytes;
    logic [63:0] word;
    logic [63:0] masked;

    assign nbytes  = i_data[67:64];
    assign word    = i_data[63:0];
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            masked[b*8 +: 8] = (4'(b) < nbytes) ? word[b*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_item.first      = i_user;
        o_item.last       = i_last;
        o_item.seed       = i_data[131:68];
        o_item.key_length = i_data[163:132];
        if (nbytes >= 4'd8) begin
            o_item.kind = KIND_FULL;
            o_item.word = word;
        end else if (nbytes != 4'd0) begin
            o_item.kind = KIND_TAIL;
            o_item.word = masked;
        end else begin
            o_item.kind = KIND_NONE;
            o_item.word = masked;
        end
    end

endmodule

FILE: hdl/mh64_queue.sv
// short item queue between front and back
`timescale 1ns / 1ps
module mh64_queue #(
    parameter int DEPTH = mh64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mh64_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output mh64_pkg::t_item o_head
);
    import mh64_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hdl/mh64_mul.sv
// iterative 64-bit multiply by the hash constant, one 32x32 partial product a cycle
`timescale 1ns / 1ps
module mh64_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mh64_pkg::t_mul_req i_req,
    output mh64_pkg::t_mul_rsp o_rsp
);
    import mh64_pkg::*;

    logic [63:0] r_a;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic [63:0] r_p;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;
    logic [63:0] shifted;

    always_comb begin
        op_x = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        op_y = (r_step == 2'd1) ? MH_MULT_HI : MH_MULT_LO;
    end

    assign prod    = {32'h0, op_x} * {32'h0, op_y};
    assign shifted = {r_prod[31:0], 32'h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
        end
        if (r_busy) begin
            case (r_step)
                2'd0: begin
                    r_prod <= prod;
                end
                2'd1: begin
                    r_sum  <= r_prod;
                    r_prod <= prod;
                end
                2'd2: begin
                    r_sum  <= r_sum + shifted;
                    r_prod <= prod;
                end
                default: begin
                    r_p <= r_sum + shifted;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

FILE: hdl/mh64_back.sv
// back side: sequences seed load, word mixing, avalanche and result register
`timescale 1ns / 1ps
module mh64_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  mh64_pkg::t_item               i_head,
    output logic                          o_pop,
    output mh64_pkg::t_mul_req            o_mul_req,
    input  mh64_pkg::t_mul_rsp            i_mul_rsp,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [mh64_pkg::M_TDATA_W-1:0] o_tdata
);
    import mh64_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LEN  = 4'd1;
    localparam logic [3:0] S_DATA = 4'd2;
    localparam logic [3:0] S_K1   = 4'd3;
    localparam logic [3:0] S_K2   = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_END  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_PUT  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_h, n_h;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data, n_out_data;
    logic [63:0] p;

    assign p = i_mul_rsp.p;

    always_comb begin
        n_state         = r_state;
        n_acc           = r_acc;
        n_h             = r_h;
        n_out_valid     = r_out_valid;
        n_out_data      = r_out_data;
        o_pop           = 1'b0;
        o_mul_req.start = 1'b0;
        o_mul_req.a     = r_acc;

        if (r_out_valid && i_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.first) begin
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = {32'h0, i_head.key_length};
                        n_state         = S_LEN;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_LEN: begin
                if (i_mul_rsp.done) begin
                    n_acc   = i_head.seed ^ p;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                case (i_head.kind)
                    KIND_FULL: begin
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = i_head.word;
                        n_state         = S_K1;
                    end
                    KIND_TAIL: begin
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = r_acc ^ i_head.word;
                        n_state         = S_ACC;
                    end
                    default: begin
                        n_state = S_END;
                    end
                endcase
            end
            S_K1: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = p ^ (p >> MH_SHIFT);
                    n_state         = S_K2;
                end
            end
            S_K2: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_acc ^ p;
                    n_state         = S_ACC;
                end
            end
            S_ACC: begin
                if (i_mul_rsp.done) begin
                    n_acc   = p;
                    n_state = S_END;
                end
            end
            S_END: begin
                if (i_head.last) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_acc ^ (r_acc >> MH_SHIFT);
                    n_acc           = '0;
                    n_state         = S_FIN;
                end else begin
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_mul_rsp.done) begin
                    n_h     = p ^ (p >> MH_SHIFT);
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_h;
                    o_pop       = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_out_data <= n_out_data;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule

FILE: hdl/murmur_hash64a_engine.sv
// top level of the streaming murmurhash64a engine
//
//  channel   dir  handshake        tdata / tuser / tlast
//  s_axis    in   tvalid, tready   tdata: data_word, valid_bytes, seed_value, key_length
//                                  tuser: first_word   tlast: last_word
//  m_axis    out  tvalid, tready   tdata: hash_value
//
// each 64-bit multiply runs on one shared 32x32 multiplier; a word needs m multiplies,
// m = 1 for a first word, 3 for a full word or 1 for a tail,
// and 1 more for a last word, before the hash is loaded into the result register
// synchronous active-low reset clears the queue, sequencer and accumulator
// the queue takes transfers while it is not full, also while the back end works or the result waits
`timescale 1ns / 1ps
module murmur_hash64a_engine #(
    parameter int QUEUE_DEPTH = mh64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // data_word[63:0], valid_bytes[67:64], seed_value[131:68], key_length[163:132], zero pad
    input  logic [mh64_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    // first_word
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // hash_value[63:0]
    output logic [mh64_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import mh64_pkg::*;

    t_item    push_item;
    t_item    head;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_valid;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    mh64_front u_front (
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_user  (i_s_axis_tuser),
        .i_full  (q_full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_item  (push_item)
    );

    mh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    mh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    mh64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata)
    );

endmodule

FILE: hdl/mh64_checker.sv
// port-level checks of the murmurhash64a engine and their bind
`timescale 1ns / 1ps
module mh64_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [mh64_pkg::M_TDATA_W-1:0] i_m_axis_tdata
);
    import mh64_pkg::*;

    logic [7:0] r_pend;
    logic       in_last;
    logic       out_xfer;

    assign in_last  = i_s_axis_tvalid && i_s_axis_tready && i_s_axis_tlast;
    assign out_xfer = i_m_axis_tvalid && i_m_axis_tready;

    // keys whose last word was taken but whose hash is not yet out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_last && !out_xfer) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_xfer && !in_last) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_s_axis_tready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> r_pend != 8'd0)
        else $error("result without a finished key");

endmodule

bind murmur_hash64a_engine mh64_checker u_mh64_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
